>>> design/wbct_pkg.sv
// ----------------------------------------------------------------------------
// wbct_pkg
// shared types and constants of the windowed blob centroid tracker
// ----------------------------------------------------------------------------
package wbct_pkg;

  localparam int IMG_HEIGHT = 120;
  localparam int IMG_WIDTH  = 160;

  localparam int ROW_W   = 7;
  localparam int COL_W   = 8;
  localparam int VALUE_W = 8;
  localparam int SUM_W   = 22;
  localparam int COUNT_W = 15;
  localparam int SPEED_ROW_W = 8;
  localparam int SPEED_COL_W = 9;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 8;

  localparam logic [CFG_INDEX_W-1:0] REG_ROW_MIN = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_ROW_MAX = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_COL_MIN = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_COL_MAX = 2'd3;

  localparam logic [ROW_W-1:0] ROW_MAX_RESET = ROW_W'(IMG_HEIGHT);
  localparam logic [COL_W-1:0] COL_MAX_RESET = COL_W'(IMG_WIDTH);

  localparam int DIV_STEPS = SUM_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  typedef struct packed {
    logic accept;
    logic start_div;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic out_free;
  } status_t;

endpackage

>>> design/wbct_div.sv
// ----------------------------------------------------------------------------
// wbct_div
// restoring divider, one quotient bit per clock
// ----------------------------------------------------------------------------
module wbct_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [wbct_pkg::SUM_W-1:0]    dividend,
  input  logic [wbct_pkg::COUNT_W-1:0]  divisor,
  output logic                          busy,
  output logic                          done,
  output logic [wbct_pkg::SUM_W-1:0]    quotient
);
  import wbct_pkg::*;

  logic [SUM_W-1:0]     quo;
  logic [COUNT_W-1:0]   rem;
  logic [COUNT_W-1:0]   dsr;
  logic [DIV_CNT_W-1:0] cnt;
  logic [COUNT_W:0]     shifted;
  logic [COUNT_W:0]     diff;
  logic                 fits;

  assign shifted = {rem, quo[SUM_W-1]};
  assign fits    = shifted >= {1'b0, dsr};
  assign diff    = shifted - {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dsr <= divisor;
    end else if (busy) begin
      quo <= {quo[SUM_W-2:0], fits};
      rem <= fits ? diff[COUNT_W-1:0] : shifted[COUNT_W-1:0];
    end
  end

  assign quotient = quo;

`ifndef SYNTHESIS
  a_start_busy: assert property (@(posedge clk) disable iff (rst) start |=> busy)
    else $error("divider not busy after start");
`endif

endmodule

>>> design/wbct_datapath.sv
// ----------------------------------------------------------------------------
// wbct_datapath
// window registers, accumulators, dividers and output register
// ----------------------------------------------------------------------------
module wbct_datapath (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [wbct_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [wbct_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic [wbct_pkg::VALUE_W-1:0]      pixel_value,
  input  logic [wbct_pkg::ROW_W-1:0]        pixel_row,
  input  logic [wbct_pkg::COL_W-1:0]        pixel_col,
  input  wbct_pkg::cmd_t                    cmd,
  output wbct_pkg::status_t                 status,
  output logic [wbct_pkg::ROW_W-1:0]        center_row,
  output logic [wbct_pkg::COL_W-1:0]        center_col,
  output logic [wbct_pkg::SPEED_ROW_W-1:0]  speed_row,
  output logic [wbct_pkg::SPEED_COL_W-1:0]  speed_col,
  output logic                              target_found,
  output logic                              out_valid,
  input  logic                              out_ready
);
  import wbct_pkg::*;

  logic [ROW_W-1:0]   row_min, row_max;
  logic [COL_W-1:0]   col_min, col_max;
  logic [SUM_W-1:0]   row_sum, col_sum;
  logic [COUNT_W-1:0] hit_count;
  logic [ROW_W-1:0]   prev_center_row;
  logic [COL_W-1:0]   prev_center_col;
  logic               none_found;

  logic               hit, room;
  logic [SUM_W:0]     row_sum_try, col_sum_try;
  logic [SUM_W-1:0]   row_sum_next, col_sum_next;
  logic [COUNT_W-1:0] hit_count_next;

  logic               row_busy, col_busy, row_done, col_done;
  logic [SUM_W-1:0]   row_quo, col_quo;

  logic [ROW_W-1:0]   cr;
  logic [COL_W-1:0]   cc;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_min <= '0;
      row_max <= ROW_MAX_RESET;
      col_min <= '0;
      col_max <= COL_MAX_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ROW_MIN: row_min <= cfg_data[ROW_W-1:0];
        REG_ROW_MAX: row_max <= cfg_data[ROW_W-1:0];
        REG_COL_MIN: col_min <= cfg_data[COL_W-1:0];
        REG_COL_MAX: col_max <= cfg_data[COL_W-1:0];
      endcase
    end
  end

  // target pixel inside image and window
  assign hit = (pixel_value == '0) &&
               (int'(pixel_row) < IMG_HEIGHT) && (int'(pixel_col) < IMG_WIDTH) &&
               (pixel_row >= row_min) && (pixel_row < row_max) &&
               (pixel_col >= col_min) && (pixel_col < col_max);

  assign row_sum_try = {1'b0, row_sum} + (SUM_W+1)'(pixel_row);
  assign col_sum_try = {1'b0, col_sum} + (SUM_W+1)'(pixel_col);
  assign room = (hit_count != '1) && !row_sum_try[SUM_W] && !col_sum_try[SUM_W];

  always_comb begin
    row_sum_next   = row_sum;
    col_sum_next   = col_sum;
    hit_count_next = hit_count;
    if (hit && room) begin
      row_sum_next   = row_sum_try[SUM_W-1:0];
      col_sum_next   = col_sum_try[SUM_W-1:0];
      hit_count_next = hit_count + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_sum   <= '0;
      col_sum   <= '0;
      hit_count <= '0;
    end else if (cmd.start_div) begin
      row_sum   <= '0;
      col_sum   <= '0;
      hit_count <= '0;
    end else if (cmd.accept) begin
      row_sum   <= row_sum_next;
      col_sum   <= col_sum_next;
      hit_count <= hit_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start_div) begin
      none_found <= (hit_count_next == '0);
    end
  end

  wbct_div u_row_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.start_div),
    .dividend (row_sum_next),
    .divisor  (hit_count_next),
    .busy     (row_busy),
    .done     (row_done),
    .quotient (row_quo)
  );

  wbct_div u_col_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.start_div),
    .dividend (col_sum_next),
    .divisor  (hit_count_next),
    .busy     (col_busy),
    .done     (col_done),
    .quotient (col_quo)
  );

  assign cr = none_found ? prev_center_row : row_quo[ROW_W-1:0];
  assign cc = none_found ? prev_center_col : col_quo[COL_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_center_row <= '0;
      prev_center_col <= '0;
      out_valid       <= 1'b0;
    end else begin
      if (cmd.load_out) begin
        prev_center_row <= cr;
        prev_center_col <= cc;
        out_valid       <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      center_row   <= cr;
      center_col   <= cc;
      speed_row    <= {1'b0, cr} - {1'b0, prev_center_row};
      speed_col    <= {1'b0, cc} - {1'b0, prev_center_col};
      target_found <= !none_found;
    end
  end

  assign status.div_done = row_done && col_done && !row_busy && !col_busy;
  assign status.out_free = !out_valid || out_ready;

`ifndef SYNTHESIS
  a_load_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |=> out_valid)
    else $error("result word lost after load");
  a_no_target_speed: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !target_found) |-> (speed_row == '0 && speed_col == '0))
    else $error("nonzero speed without target");
  a_div_lockstep: assert property (@(posedge clk) disable iff (rst)
    row_done == col_done)
    else $error("dividers out of step");
`endif

endmodule

>>> design/wbct_ctrl.sv
// ----------------------------------------------------------------------------
// wbct_ctrl
// controller: pixel intake, frame-end divide, result hand-off
// ----------------------------------------------------------------------------
module wbct_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_last,
  output logic               in_ready,
  input  wbct_pkg::status_t  status,
  output wbct_pkg::cmd_t     cmd
);
  import wbct_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_OUT  = 2'd2;

  logic [1:0] state, state_next;

  assign in_ready      = (state == ST_IDLE);
  assign cmd.accept    = in_valid && in_ready;
  assign cmd.start_div = cmd.accept && in_last;
  assign cmd.load_out  = (state == ST_OUT) && status.out_free;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (cmd.start_div) state_next = ST_DIV;
      ST_DIV:  if (status.div_done) state_next = ST_OUT;
      ST_OUT:  if (status.out_free) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

`ifndef SYNTHESIS
  a_done_in_div: assert property (@(posedge clk) disable iff (rst)
    status.div_done |-> state == ST_DIV)
    else $error("divide finished outside divide state");
`endif

endmodule

>>> design/windowed_blob_centroid_tracker.sv
// ----------------------------------------------------------------------------
// windowed_blob_centroid_tracker
// centroid and frame-to-frame speed of zero-valued pixels inside a window
// ----------------------------------------------------------------------------
// Pixels are taken one per clock in raster order. The pixel flagged by tlast
// closes the frame: the input then stalls while two bit-serial dividers (22
// steps, one quotient bit per clock) form the centroid, and longer if the
// previous result word has not yet been taken. One result word leaves per
// frame; the window registers must be written by the user through the cfg
// port while no frame is in progress; the block itself does not enforce it.
module windowed_blob_centroid_tracker (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // pixel_value[7:0], pixel_row[14:8], pixel_col[22:15], zero pad
  input  logic [23:0] s_axis_tdata,
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // center_row[6:0], center_col[14:7], speed_row[22:15], speed_col[31:23]
  output logic [31:0] m_axis_tdata,
  // target_found[0]
  output logic        m_axis_tuser
);
  import wbct_pkg::*;

  cmd_t                   cmd;
  status_t                status;
  logic [ROW_W-1:0]       center_row;
  logic [COL_W-1:0]       center_col;
  logic [SPEED_ROW_W-1:0] speed_row;
  logic [SPEED_COL_W-1:0] speed_col;

  wbct_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_last  (s_axis_tlast),
    .in_ready (s_axis_tready),
    .status   (status),
    .cmd      (cmd)
  );

  wbct_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .pixel_value  (s_axis_tdata[7:0]),
    .pixel_row    (s_axis_tdata[14:8]),
    .pixel_col    (s_axis_tdata[22:15]),
    .cmd          (cmd),
    .status       (status),
    .center_row   (center_row),
    .center_col   (center_col),
    .speed_row    (speed_row),
    .speed_col    (speed_col),
    .target_found (m_axis_tuser),
    .out_valid    (m_axis_tvalid),
    .out_ready    (m_axis_tready)
  );

  assign m_axis_tdata = {speed_col, speed_row, center_col, center_row};

endmodule
